>>> hw/rtl/smt_pkg.sv
// smt_pkg: shared types, constants and helper functions for the sprite motion tweener
// no dependencies; imported by every module of the block
package smt_pkg;

    localparam int NUM_SPRITES_DEF = 8;
    localparam int EASE_N          = 32;
    localparam int TIME_W          = 24;
    localparam int EL_W            = 9;
    localparam int POS_W           = 13;

    localparam logic [2:0] POP_PX  = 3'd4;
    localparam logic [2:0] HOP_PX  = 3'd5;
    localparam logic [2:0] SINK_PX = 3'd5;

    localparam logic [TIME_W-1:0] POP_MS       = 24'd250;
    localparam logic [TIME_W-1:0] HOP_MS       = 24'd200;
    localparam logic [TIME_W-1:0] HOP_HALF_MS  = 24'd100;
    localparam logic [TIME_W-1:0] SINK_FALL_MS = 24'd500;
    localparam logic [TIME_W-1:0] SINK_RISE_MS = 24'd150;

    localparam logic [7:0] EASE_TAB [EASE_N] = '{
        8'd255, 8'd254, 8'd252, 8'd249, 8'd245, 8'd239, 8'd232, 8'd224,
        8'd215, 8'd206, 8'd195, 8'd184, 8'd172, 8'd159, 8'd147, 8'd134,
        8'd121, 8'd108, 8'd96,  8'd83,  8'd71,  8'd60,  8'd49,  8'd40,
        8'd31,  8'd23,  8'd16,  8'd10,  8'd6,   8'd3,   8'd1,   8'd0
    };

    typedef enum logic [1:0] {
        DUR_100 = 2'd0,
        DUR_150 = 2'd1,
        DUR_250 = 2'd2,
        DUR_500 = 2'd3
    } t_dur;

    typedef struct packed {
        logic [EL_W-1:0] el;
        t_dur            dur;
        logic [2:0]      mag;
    } t_ease_req;

    typedef struct packed {
        logic              zoom_flag;
        logic [TIME_W-1:0] zoom_change_time;
        logic              zoom_armed;
        logic [7:0]        last_show_count;
        logic [TIME_W-1:0] hop_start_time;
        logic              sink_flag;
        logic [TIME_W-1:0] sink_change_time;
        logic              sink_armed;
    } t_sprite_state;

    function automatic logic [8:0] dur_ms(input t_dur d);
        logic [8:0] v;
        case (d)
            DUR_100: v = 9'd100;
            DUR_150: v = 9'd150;
            DUR_250: v = 9'd250;
            DUR_500: v = 9'd500;
            default: v = 9'd100;
        endcase
        return v;
    endfunction

    // floor(2^32 / duration)
    function automatic logic [25:0] dur_recip(input t_dur d);
        logic [25:0] v;
        case (d)
            DUR_100: v = 26'd42949672;
            DUR_150: v = 26'd28633115;
            DUR_250: v = 26'd17179869;
            DUR_500: v = 26'd8589934;
            default: v = 26'd42949672;
        endcase
        return v;
    endfunction

    // truncating divide by 255 for products up to 5 * 255
    function automatic logic [2:0] div255(input logic [10:0] p);
        logic [2:0] m;
        m = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            if (p >= 11'(k * 255)) begin
                m = 3'(k);
            end
        end
        return m;
    endfunction

endpackage

>>> hw/rtl/smt_if.sv
// smt_in_if / smt_out_if: valid-ready channels carrying requests and results
// depends on nothing but the request field widths
interface smt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  sprite_id;
    logic        zoom_on;
    logic        hop_active;
    logic [7:0]  show_count;
    logic        sink_wanted;
    logic [23:0] time_ms;

    modport source (output valid, sprite_id, zoom_on, hop_active, show_count,
                    sink_wanted, time_ms, input ready);
    modport sink   (input valid, sprite_id, zoom_on, hop_active, show_count,
                    sink_wanted, time_ms, output ready);
endinterface

interface smt_out_if;
    logic              valid;
    logic              ready;
    logic signed [2:0] pop_offset;
    logic signed [3:0] feet_offset;
    logic              moving;

    modport source (output valid, pop_offset, feet_offset, moving, input ready);
    modport sink   (input valid, pop_offset, feet_offset, moving, output ready);
endinterface

>>> hw/rtl/sprite_motion_tweener.sv
// sprite_motion_tweener: top level, sequencer around the shared ease unit and state store
// depends on smt_pkg, smt_if, smt_ease_unit and smt_state_mem
//
// usage:
//   i_in carries one request per sprite update: sprite id, wanted zoom, hop and
//   sink flags, show sequence number and the time in ms. o_out returns one
//   result per request: eased pop offset, feet offset and the moving flag.
//   a request is taken when valid and ready are both high at a rising edge.
//   i_in.ready is high only while the block is idle; one request is handled
//   at a time.
//   a request goes through a state read, then three serial passes through
//   the single ease unit for pop, hop and sink, before its result is valid.
//   the block takes no new request until the result of the last one has
//   been accepted; the three serial passes through the ease unit bound the rate.
//   the result is held in an output register until o_out.ready is seen; a
//   stalled receiver holds the block and the next request waits.
//   reset (i_rst_n low, synchronous) clears all sprite state to zero at once.
//   sprite ids at or above the sprite count wrap modulo that count.
module sprite_motion_tweener
    import smt_pkg::*;
#(
    parameter int NUM_SPRITES = NUM_SPRITES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    smt_in_if.sink    i_in,
    smt_out_if.source o_out
);

    localparam int IDX_W = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_RD   = 9'b000000010,
        ST_EZ   = 9'b000000100,
        ST_WZ   = 9'b000001000,
        ST_EH   = 9'b000010000,
        ST_WH   = 9'b000100000,
        ST_ES   = 9'b001000000,
        ST_WS   = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    function automatic logic [IDX_W-1:0] slot_of(input logic [2:0] id);
        logic [6:0] v;
        v = 7'(id);
        for (int i = 0; i < 7; i++) begin
            if (v >= 7'(NUM_SPRITES)) begin
                v = v - 7'(NUM_SPRITES);
            end
        end
        return v[IDX_W-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_slot;
    logic              r_zw, r_hop_en, r_sw;
    logic [7:0]        r_seq;
    logic [TIME_W-1:0] r_t;
    t_sprite_state     r_st, n_st;
    logic              r_act, r_first, r_mov;
    logic signed [2:0] r_pop;
    logic signed [3:0] r_hopv;
    logic signed [3:0] r_feet;

    t_sprite_state     rd_data;
    logic              accept;
    logic              ease_start, ease_done;
    logic [2:0]        ease_m, m_used;
    t_ease_req         ease_req;
    logic [TIME_W-1:0] el, el_e;
    logic [TIME_W-1:0] sink_dur;
    logic              act, mov_now, first;
    logic signed [3:0] sinkv;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = (r_state == ST_OUT);
    assign o_out.pop_offset  = r_pop;
    assign o_out.feet_offset = r_feet;
    assign o_out.moving      = r_mov;

    smt_state_mem #(
        .DEPTH (NUM_SPRITES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (slot_of(i_in.sprite_id)),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == ST_EZ),
        .i_wr_addr (r_slot),
        .i_wr_data (r_st)
    );

    smt_ease_unit u_ease (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ease_start),
        .i_req   (ease_req),
        .o_done  (ease_done),
        .o_mag   (ease_m)
    );

    // state update for the addressed sprite
    always_comb begin
        n_st = rd_data;
        if (r_zw != rd_data.zoom_flag) begin
            n_st.zoom_flag        = r_zw;
            n_st.zoom_change_time = r_t;
            n_st.zoom_armed       = 1'b1;
        end
        if (r_hop_en && (r_seq != rd_data.last_show_count)) begin
            n_st.last_show_count = r_seq;
            n_st.hop_start_time  = r_t;
        end
        if (r_sw != rd_data.sink_flag) begin
            n_st.sink_flag        = r_sw;
            n_st.sink_change_time = r_t;
            n_st.sink_armed       = 1'b1;
        end
    end

    // ease request set-up for each pass
    always_comb begin
        ease_start = 1'b0;
        ease_req   = '{el: '0, dur: DUR_250, mag: POP_PX};
        el         = '0;
        el_e       = '0;
        act        = 1'b0;
        mov_now    = 1'b0;
        first      = 1'b0;
        sink_dur   = r_sw ? SINK_FALL_MS : SINK_RISE_MS;
        case (r_state)
            ST_EZ: begin
                el         = r_t - r_st.zoom_change_time;
                mov_now    = (el < POP_MS);
                act        = r_st.zoom_armed && mov_now;
                ease_start = 1'b1;
                ease_req   = '{el: act ? el[EL_W-1:0] : '0, dur: DUR_250, mag: POP_PX};
            end
            ST_EH: begin
                el         = r_t - r_st.hop_start_time;
                mov_now    = r_hop_en && (el < HOP_MS);
                act        = mov_now;
                first      = act && (el < HOP_HALF_MS);
                el_e       = first ? el : el - HOP_HALF_MS;
                ease_start = 1'b1;
                ease_req   = '{el: act ? el_e[EL_W-1:0] : '0, dur: DUR_100, mag: HOP_PX};
            end
            ST_ES: begin
                el         = r_t - r_st.sink_change_time;
                mov_now    = (el < sink_dur);
                act        = r_st.sink_armed && mov_now;
                ease_start = 1'b1;
                ease_req   = '{el: act ? el[EL_W-1:0] : '0,
                               dur: r_sw ? DUR_500 : DUR_150, mag: SINK_PX};
            end
            default: begin
                ease_start = 1'b0;
            end
        endcase
    end

    assign m_used = r_act ? ease_m : 3'd0;
    assign sinkv  = r_sw ? 4'(SINK_PX) - 4'(m_used) : 4'(m_used);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_RD;
            ST_RD:   n_state = ST_EZ;
            ST_EZ:   n_state = ST_WZ;
            ST_WZ:   if (ease_done) n_state = ST_EH;
            ST_EH:   n_state = ST_WH;
            ST_WH:   if (ease_done) n_state = ST_ES;
            ST_ES:   n_state = ST_WS;
            ST_WS:   if (ease_done) n_state = ST_OUT;
            ST_OUT:  if (o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot   <= slot_of(i_in.sprite_id);
            r_zw     <= i_in.zoom_on;
            r_hop_en <= i_in.hop_active;
            r_seq    <= i_in.show_count;
            r_sw     <= i_in.sink_wanted;
            r_t      <= i_in.time_ms;
        end
        if (r_state == ST_RD) begin
            r_st <= n_st;
        end
        if (r_state == ST_EZ) begin
            r_mov <= mov_now;
        end else if ((r_state == ST_EH) || (r_state == ST_ES)) begin
            r_mov <= r_mov | mov_now;
        end
        if (ease_start) begin
            r_act   <= act;
            r_first <= first;
        end
        if ((r_state == ST_WZ) && ease_done) begin
            r_pop <= r_zw ? 3'(m_used) - 3'(POP_PX) : -3'(m_used);
        end
        if ((r_state == ST_WH) && ease_done) begin
            r_hopv <= r_first ? 4'(m_used) - 4'(HOP_PX) : -4'(m_used);
        end
        if ((r_state == ST_WS) && ease_done) begin
            r_feet <= r_hopv + sinkv;
        end
    end

`ifndef SYNTHESIS
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RD))
        else $error("request not followed by state read");

    a_ease_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ease_start |-> ##4 ease_done)
        else $error("ease unit result not on time");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.pop_offset <= 3'sd0) &&
                        (o_out.feet_offset >= -4'sd5) && (o_out.feet_offset <= 4'sd5))
        else $error("result offset out of range");

    a_no_start_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WZ) || (r_state == ST_WH) || (r_state == ST_WS)) |-> !ease_start)
        else $error("ease unit restarted mid pass");
`endif

endmodule

>>> hw/rtl/smt_ease_unit.sv
// smt_ease_unit: shared four-stage ease evaluator (scaled time, table interpolation, scaling)
// depends on smt_pkg
module smt_ease_unit
    import smt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_ease_req  i_req,
    output logic       o_done,
    output logic [2:0] o_mag
);

    logic [3:0]       r_v;
    logic [21:0]      r_x;
    logic [47:0]      r_prod;
    t_dur             r_dur;
    logic [2:0]       r_mag1, r_mag2, r_mag3;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_interp;
    logic [2:0]       r_m;

    logic [21:0]      x;
    logic [12:0]      q0;
    logic [21:0]      qd;
    logic [21:0]      rem;
    logic [8:0]       d;
    logic [4:0]       idx;
    logic [7:0]       frac, a, b, diff;
    logic [15:0]      step;

    always_comb begin
        x    = (22'(i_req.el) << 13) - (22'(i_req.el) << 8);
        d    = dur_ms(r_dur);
        q0   = r_prod[44:32];
        qd   = 22'(q0) * 22'(d);
        rem  = r_x - qd;
        idx  = r_pos[12:8];
        frac = r_pos[7:0];
        a    = EASE_TAB[idx];
        b    = (idx == 5'(EASE_N - 1)) ? 8'd0 : EASE_TAB[idx + 5'd1];
        diff = a - b;
        step = 16'(diff) * 16'(frac) + 16'd255;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= x;
            r_prod <= 48'(x) * 48'(dur_recip(i_req.dur));
            r_dur  <= i_req.dur;
            r_mag1 <= i_req.mag;
        end
        if (r_v[0]) begin
            r_pos  <= (rem >= 22'(d)) ? q0 + 13'd1 : q0;
            r_mag2 <= r_mag1;
        end
        if (r_v[1]) begin
            r_interp <= a - step[15:8];
            r_mag3   <= r_mag2;
        end
        if (r_v[2]) begin
            r_m <= div255(11'(r_mag3) * 11'(r_interp));
        end
    end

    assign o_done = r_v[3];
    assign o_mag  = r_m;

endmodule

>>> hw/rtl/smt_state_mem.sv
// smt_state_mem: per-sprite motion state store with one valid bit per entry
// depends on smt_pkg; entries not yet written read as all zero
module smt_state_mem
    import smt_pkg::*;
#(
    parameter int DEPTH = NUM_SPRITES_DEF,
    parameter int IDX_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_sprite_state    o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_sprite_state    i_wr_data
);

    t_sprite_state mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_sprite_state    r_q;
    logic             r_qv;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_qv <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_qv ? r_q : '0;

endmodule

>>> tb/sv/tb_sprite_motion_tweener.sv
// tb_sprite_motion_tweener: self-checking bench for the sprite motion tweener
// depends on smt_pkg, smt_if and sprite_motion_tweener; predicts every result in-line
`timescale 1ns / 100ps
module tb_sprite_motion_tweener;
    import smt_pkg::*;

    typedef struct packed {
        logic [2:0]  sprite_id;
        logic        zoom_on;
        logic        hop_active;
        logic [7:0]  show_count;
        logic        sink_wanted;
        logic [23:0] time_ms;
    } t_motion_req;

    typedef struct packed {
        logic signed [2:0] pop_offset;
        logic signed [3:0] feet_offset;
        logic              moving;
    } t_motion_res;

    logic i_clk;
    logic i_rst_n;
    smt_in_if  in_ch ();
    smt_out_if out_ch ();

    sprite_motion_tweener dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    t_motion_req   pending_reqs[$];
    t_motion_res   expected_res[$];
    t_sprite_state sprite_model[8];
    int            err_count;
    int            cycle_count;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_cycles;
    bit            send_pause;
    bit            stim_done;
    logic [23:0]   clock_ms;
    bit            zoom_hint[8];
    bit            sink_hint[8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int ease_remaining(int amp, int elapsed, int dur);
        int pos, idx, frac, a, b, interp, mag, m;
        if (elapsed == 0) return amp;
        if (elapsed >= dur) return 0;
        pos    = elapsed * ((EASE_N - 1) << 8) / dur;
        idx    = (pos >> 8) & (EASE_N - 1);
        frac   = pos & 255;
        a      = EASE_TAB[idx];
        b      = (idx + 1 < EASE_N) ? EASE_TAB[idx + 1] : 0;
        interp = a - (((a - b) * frac + 255) >> 8);
        mag    = (amp < 0) ? -amp : amp;
        m      = mag * interp / 255;
        return (amp < 0) ? -m : m;
    endfunction

    function automatic t_motion_res predict_motion(t_motion_req r);
        t_motion_res res;
        int          s, el, pop, feet, hopv, rest, opp, dur;
        bit          mv;
        s    = r.sprite_id;
        mv   = 1'b0;
        hopv = 0;
        if (r.zoom_on != sprite_model[s].zoom_flag) begin
            sprite_model[s].zoom_flag        = r.zoom_on;
            sprite_model[s].zoom_change_time = r.time_ms;
            sprite_model[s].zoom_armed       = 1'b1;
        end
        rest = r.zoom_on ? -4 : 0;
        opp  = r.zoom_on ? 0 : -4;
        el   = 24'(r.time_ms - sprite_model[s].zoom_change_time);
        if (el < 250) mv = 1'b1;
        pop = rest + (sprite_model[s].zoom_armed ? ease_remaining(opp - rest, el, 250) : 0);
        if (r.hop_active) begin
            if (r.show_count != sprite_model[s].last_show_count) begin
                sprite_model[s].last_show_count = r.show_count;
                sprite_model[s].hop_start_time  = r.time_ms;
            end
            el = 24'(r.time_ms - sprite_model[s].hop_start_time);
            if (el < 200) begin
                mv = 1'b1;
                if (el < 100) hopv = -5 + ease_remaining(5, el, 100);
                else hopv = ease_remaining(-5, el - 100, 100);
            end
        end
        if (r.sink_wanted != sprite_model[s].sink_flag) begin
            sprite_model[s].sink_flag        = r.sink_wanted;
            sprite_model[s].sink_change_time = r.time_ms;
            sprite_model[s].sink_armed       = 1'b1;
        end
        rest = r.sink_wanted ? 5 : 0;
        opp  = r.sink_wanted ? 0 : 5;
        dur  = r.sink_wanted ? 500 : 150;
        el   = 24'(r.time_ms - sprite_model[s].sink_change_time);
        if (el < dur) mv = 1'b1;
        feet = hopv + rest
             + (sprite_model[s].sink_armed ? ease_remaining(opp - rest, el, dur) : 0);
        res.pop_offset  = 3'(pop);
        res.feet_offset = 4'(feet);
        res.moving      = mv;
        return res;
    endfunction

    function automatic t_motion_req make_req(int sid, bit zw, bit hop, int seq, bit sw,
                                             logic [23:0] t);
        t_motion_req r;
        r.sprite_id   = 3'(sid);
        r.zoom_on     = zw;
        r.hop_active  = hop;
        r.show_count  = 8'(seq);
        r.sink_wanted = sw;
        r.time_ms     = t;
        return r;
    endfunction

    function automatic bit sprite_model_hint(t_motion_req r, bit which);
        return which ? sink_hint[r.sprite_id] : zoom_hint[r.sprite_id];
    endfunction

    // realistic frames: time mostly advances in small steps so eases are sampled mid-flight
    task automatic add_frames(int n);
        t_motion_req r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) clock_ms = 24'($urandom);
            else clock_ms = clock_ms + 24'($urandom_range(0, 40));
            r = make_req($urandom_range(0, 7), $urandom_range(0, 9) < 3,
                         $urandom_range(0, 3) != 0, $urandom_range(0, 3), $urandom_range(0, 9) < 3,
                         clock_ms);
            r.zoom_on     = ($urandom_range(0, 5) == 0) ? ~sprite_model_hint(r, 0) :
                            sprite_model_hint(r, 0);
            r.sink_wanted = ($urandom_range(0, 5) == 0) ? ~sprite_model_hint(r, 1) :
                            sprite_model_hint(r, 1);
            if ($urandom_range(0, 9) == 0) r = t_motion_req'(38'({$urandom, $urandom}));
            pending_reqs.push_back(r);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_res.size() != 0 || in_ch.valid)
            @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                expected_res.push_back(predict_motion(t_motion_req'({in_ch.sprite_id,
                    in_ch.zoom_on, in_ch.hop_active, in_ch.show_count, in_ch.sink_wanted,
                    in_ch.time_ms})));
            end
            if (pending_reqs.size() != 0 && !send_pause
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                t_motion_req r;
                r = pending_reqs.pop_front();
                zoom_hint[r.sprite_id] <= r.zoom_on;
                sink_hint[r.sprite_id] <= r.sink_wanted;
                {in_ch.sprite_id, in_ch.zoom_on, in_ch.hop_active, in_ch.show_count,
                 in_ch.sink_wanted, in_ch.time_ms} <= r;
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_res.size() == 0) begin
                    $error("unexpected result pop=%0d feet=%0d moving=%0b",
                           out_ch.pop_offset, out_ch.feet_offset, out_ch.moving);
                    err_count++;
                end else begin
                    t_motion_res e;
                    e = expected_res.pop_front();
                    if (out_ch.pop_offset !== e.pop_offset) begin
                        $error("pop_offset expected %0d actual %0d", e.pop_offset,
                               out_ch.pop_offset);
                        err_count++;
                    end
                    if (out_ch.feet_offset !== e.feet_offset) begin
                        $error("feet_offset expected %0d actual %0d", e.feet_offset,
                               out_ch.feet_offset);
                        err_count++;
                    end
                    if (out_ch.moving !== e.moving) begin
                        $error("moving expected %0b actual %0b", e.moving, out_ch.moving);
                        err_count++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles  <= hold_cycles - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb_sprite_motion_tweener: done, errors");
            $finish;
        end
    end

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.sprite_id   = '0;
        in_ch.zoom_on     = 1'b0;
        in_ch.hop_active  = 1'b0;
        in_ch.show_count  = '0;
        in_ch.sink_wanted = 1'b0;
        in_ch.time_ms     = '0;
        out_ch.ready      = 1'b0;
        err_count         = 0;
        cycle_count       = 0;
        hold_cycles       = 0;
        send_pause        = 1'b0;
        send_idle_pct     = 14;
        recv_idle_pct     = 70;
        clock_ms          = 24'd1000;
        for (int i = 0; i < 8; i++) begin
            sprite_model[i] = '0;
            zoom_hint[i]    = 1'b0;
            sink_hint[i]    = 1'b0;
        end
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // before first change, extremes, sprite 7, wrap of time
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 24'd0));
        pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 24'd400));
        pending_reqs.push_back(make_req(7, 1, 1, 255, 1, 24'hFFFFFF));
        pending_reqs.push_back(make_req(7, 1, 1, 255, 1, 24'd50));
        pending_reqs.push_back(make_req(7, 1, 1, 255, 1, 24'd150));
        pending_reqs.push_back(make_req(7, 0, 0, 255, 0, 24'd300));
        pending_reqs.push_back(make_req(7, 0, 0, 255, 0, 24'd310));
        pending_reqs.push_back(make_req(7, 1, 0, 255, 1, 24'd320));
        pending_reqs.push_back(make_req(7, 0, 0, 255, 0, 24'd400));
        pending_reqs.push_back(make_req(7, 0, 0, 255, 0, 24'd1000));
        // hop sweep on one show, elapsed 0, mid, 100, 199, 200
        pending_reqs.push_back(make_req(2, 0, 1, 9, 0, 24'd5000));
        pending_reqs.push_back(make_req(2, 0, 1, 9, 0, 24'd5037));
        pending_reqs.push_back(make_req(2, 0, 1, 9, 0, 24'd5100));
        pending_reqs.push_back(make_req(2, 0, 1, 9, 0, 24'd5199));
        pending_reqs.push_back(make_req(2, 0, 1, 9, 0, 24'd5200));
        // sink down then up, sampled mid-ease, with zoom at 249
        pending_reqs.push_back(make_req(3, 1, 0, 0, 1, 24'd6000));
        pending_reqs.push_back(make_req(3, 1, 0, 0, 1, 24'd6249));
        pending_reqs.push_back(make_req(3, 1, 0, 0, 1, 24'd6499));
        pending_reqs.push_back(make_req(3, 1, 0, 0, 0, 24'd6600));
        pending_reqs.push_back(make_req(3, 1, 0, 0, 0, 24'd6675));
        wait_drained();

        add_frames(300);
        @(posedge i_clk);
        hold_cycles <= 300;
        wait_drained();
        send_pause <= 1'b1;
        repeat (20) @(posedge i_clk);
        send_pause <= 1'b0;

        send_idle_pct = 70;
        recv_idle_pct = 14;
        add_frames(300);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_frames(330);
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (err_count == 0 && expected_res.size() == 0) begin
            $display("tb_sprite_motion_tweener: done, clean");
        end else begin
            $display("tb_sprite_motion_tweener: done, errors");
        end
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/smt_pkg.sv
hw/rtl/smt_if.sv
hw/rtl/smt_ease_unit.sv
hw/rtl/smt_state_mem.sv
hw/rtl/sprite_motion_tweener.sv
tb/sv/tb_sprite_motion_tweener.sv
